/* rtl/mfrb_pkg.sv */
// Package for the multi-frame reassembly buffer: sizes, derived widths,
// opcode and status codes, and the group base-address helper.
// No dependencies.
package mfrb_pkg;

    // Buffer geometry
    localparam int GROUPS          = 8;
    localparam int BYTES_PER_GROUP = 64;
    localparam int FRAME_BYTES     = 8;

    // Derived widths
    localparam int GRP_W     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int POS_W     = $clog2(BYTES_PER_GROUP);
    localparam int FILL_W    = $clog2(BYTES_PER_GROUP + 1);
    localparam int RAM_DEPTH = GROUPS * BYTES_PER_GROUP;
    localparam int ADDR_W    = $clog2(RAM_DEPTH);
    localparam int CNT_W     = $clog2(RAM_DEPTH + 1);

    // Stream word widths
    localparam int S_TDATA_W = 80;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 3;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_READ   = 2'd1,
        OP_CLEAR  = 2'd2
    } t_opcode;

    typedef enum logic [2:0] {
        ST_NEW      = 3'd0,
        ST_APPENDED = 3'd1,
        ST_NO_FREE  = 3'd2,
        ST_OVERFLOW = 3'd3,
        ST_DONE     = 3'd4
    } t_status;

    // First RAM address of a group
    function automatic logic [ADDR_W-1:0] grp_base(input logic [GRP_W-1:0] grp);
        return ADDR_W'(grp) * ADDR_W'(BYTES_PER_GROUP);
    endfunction

endpackage

/* rtl/mfrb_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mfrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port, read port; read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/multi_frame_reassembly_buffer.sv */
// Multi-frame reassembly buffer: groups frames by their id byte into byte
// buffers held in one RAM. Depends on mfrb_pkg and mfrb_ram.
//
//  channel  dir  handshake              payload
//  s        in   i_s_tvalid/o_s_tready  tuser: opcode; tdata: frame, size, select, offset
//  m        out  o_m_tvalid/i_m_tready  tuser: status; tdata: slot, length, read byte
//
// Each word passes decode, then the byte write loop (append) or the clear sweep
// (clear), then finish; rejected appends, reads, unused opcodes and clears of a
// bad group go straight to finish. The single RAM write port stores one byte per cycle.
// After reset a clearing pass zeroes all GROUPS*BYTES_PER_GROUP (512) RAM bytes;
// o_s_tready stays low meanwhile. Reset is synchronous, active low.
// A result waiting on o_m_tvalid does not block the next input word; its
// result is held back until the output register is free.
module multi_frame_reassembly_buffer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // [63:0] frame_data, [67:64] byte_count, [70:68] group_select,
    // [76:71] byte_offset, [79:77] zero
    input  logic [mfrb_pkg::S_TDATA_W-1:0] i_s_tdata,
    // [1:0] opcode
    input  logic [mfrb_pkg::S_TUSER_W-1:0] i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [2:0] group_slot, [9:3] group_length, [17:10] read_byte, [23:18] zero
    output logic [mfrb_pkg::M_TDATA_W-1:0] o_m_tdata,
    // [2:0] status
    output logic [mfrb_pkg::M_TUSER_W-1:0] o_m_tuser
);
    import mfrb_pkg::*;

    typedef enum logic [2:0] {
        S_INIT, S_IDLE, S_DECODE, S_APPEND, S_CLEAR, S_FINISH
    } t_state;

    t_state               r_state;
    t_opcode              r_op;
    logic [63:0]          r_frame;
    logic [3:0]           r_size;
    logic [2:0]           r_sel;
    logic [5:0]           r_off;
    logic [GRP_W-1:0]     r_grp;
    logic [ADDR_W-1:0]    r_waddr;
    logic [CNT_W-1:0]     r_cnt;
    logic [2:0]           r_bidx;
    logic [FILL_W-1:0]    r_new_fill;
    logic [7:0]           r_id   [GROUPS];
    logic [FILL_W-1:0]    r_fill [GROUPS];
    t_status              r_res_st;
    logic [2:0]           r_res_slot;
    logic [FILL_W-1:0]    r_res_len;
    logic                 r_res_rb;
    logic                 r_m_valid;
    logic [M_TDATA_W-1:0] r_m_data;
    logic [M_TUSER_W-1:0] r_m_user;

    logic [3:0]        n_size;
    logic              hit, free;
    logic [GRP_W-1:0]  hit_idx, free_idx, fill_idx;
    logic [FILL_W-1:0] fill_rd;
    logic              sel_ok, pos_ok;
    logic [6:0]        rd_pos;
    logic [FILL_W:0]   sum_len;
    logic              overflow;
    logic [7:0]        wr_byte;
    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_wdata, ram_rdata;
    logic [7:0]        out_rb;

    // Clamp the frame size to 1..8
    always_comb begin
        if (i_s_tdata[67:64] == 4'd0) begin
            n_size = 4'd1;
        end else if (i_s_tdata[67:64] > 4'(FRAME_BYTES)) begin
            n_size = 4'(FRAME_BYTES);
        end else begin
            n_size = i_s_tdata[67:64];
        end
    end

    // Group search on the id registers: lowest index wins
    always_comb begin
        hit      = 1'b0;
        hit_idx  = '0;
        free     = 1'b0;
        free_idx = '0;
        for (int g = GROUPS - 1; g >= 0; g--) begin
            if (r_id[g] == r_frame[7:0]) begin
                hit     = 1'b1;
                hit_idx = GRP_W'(g);
            end
            if (r_id[g] == 8'd0) begin
                free     = 1'b1;
                free_idx = GRP_W'(g);
            end
        end
    end

    // Length lookup, overflow check, read position
    assign fill_idx = (r_op == OP_APPEND) ? hit_idx : r_grp;
    assign fill_rd  = r_fill[fill_idx];
    assign sum_len  = (FILL_W + 1)'(fill_rd) + (FILL_W + 1)'(r_size);
    assign overflow = sum_len > (FILL_W + 1)'(BYTES_PER_GROUP);
    assign sel_ok   = 32'(r_sel) < GROUPS;
    assign rd_pos   = {1'b0, r_off} + 7'd1;
    assign pos_ok   = 32'(rd_pos) < BYTES_PER_GROUP;
    assign wr_byte  = r_frame[{r_bidx, 3'b000} +: 8];

    // RAM port control
    assign ram_we    = (r_state == S_INIT) || (r_state == S_CLEAR)
                       || ((r_state == S_APPEND) && (r_cnt != '0));
    assign ram_wdata = (r_state == S_APPEND) ? wr_byte : 8'd0;
    assign ram_re    = (r_state == S_DECODE) && (r_op == OP_READ) && sel_ok && pos_ok;
    assign ram_raddr = grp_base(r_grp) + ADDR_W'(POS_W'(rd_pos));

    mfrb_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_bytes (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign out_rb = r_res_rb ? ram_rdata : 8'd0;

    // Sequencer: init sweep, decode, byte write loop, clear sweep, result hand-off
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_waddr   <= '0;
            r_cnt     <= CNT_W'(RAM_DEPTH);
            r_m_valid <= 1'b0;
            for (int g = 0; g < GROUPS; g++) begin
                r_id[g]   <= 8'd0;
                r_fill[g] <= '0;
            end
        end else begin
            // finish state loads the output register itself
            if ((r_state != S_FINISH) && r_m_valid && i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_INIT: begin
                    r_waddr <= r_waddr + ADDR_W'(1);
                    r_cnt   <= r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_op    <= t_opcode'(i_s_tuser);
                        r_frame <= i_s_tdata[63:0];
                        r_size  <= n_size;
                        r_sel   <= i_s_tdata[70:68];
                        r_off   <= i_s_tdata[76:71];
                        r_grp   <= GRP_W'(i_s_tdata[70:68]);
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_res_rb <= (r_op == OP_READ) && sel_ok && pos_ok;
                    case (r_op)
                        OP_APPEND: begin
                            if (hit && overflow) begin
                                r_res_st   <= ST_OVERFLOW;
                                r_res_slot <= 3'(hit_idx);
                                r_res_len  <= fill_rd;
                                r_state    <= S_FINISH;
                            end else if (hit) begin
                                r_grp      <= hit_idx;
                                r_waddr    <= grp_base(hit_idx) + ADDR_W'(fill_rd);
                                r_bidx     <= 3'd1;
                                r_cnt      <= CNT_W'(r_size - 4'd1);
                                r_new_fill <= FILL_W'(sum_len - (FILL_W + 1)'(1));
                                r_res_st   <= ST_APPENDED;
                                r_res_slot <= 3'(hit_idx);
                                r_res_len  <= FILL_W'(sum_len - (FILL_W + 1)'(1));
                                r_state    <= S_APPEND;
                            end else if (free) begin
                                r_grp      <= free_idx;
                                r_waddr    <= grp_base(free_idx);
                                r_bidx     <= 3'd0;
                                r_cnt      <= CNT_W'(r_size);
                                r_new_fill <= FILL_W'(FRAME_BYTES);
                                r_res_st   <= ST_NEW;
                                r_res_slot <= 3'(free_idx);
                                r_res_len  <= FILL_W'(FRAME_BYTES);
                                r_state    <= S_APPEND;
                            end else begin
                                r_res_st   <= ST_NO_FREE;
                                r_res_slot <= 3'd0;
                                r_res_len  <= '0;
                                r_state    <= S_FINISH;
                            end
                        end
                        OP_READ: begin
                            r_res_st   <= ST_DONE;
                            r_res_slot <= r_sel;
                            r_res_len  <= sel_ok ? fill_rd : '0;
                            r_state    <= S_FINISH;
                        end
                        OP_CLEAR: begin
                            r_res_st   <= ST_DONE;
                            r_res_slot <= r_sel;
                            r_res_len  <= '0;
                            if (sel_ok) begin
                                r_id[r_grp]   <= 8'd0;
                                r_fill[r_grp] <= '0;
                                r_waddr       <= grp_base(r_grp);
                                r_cnt         <= CNT_W'(BYTES_PER_GROUP);
                                r_state       <= S_CLEAR;
                            end else begin
                                r_state <= S_FINISH;
                            end
                        end
                        default: begin
                            // unused opcode: report only
                            r_res_st   <= ST_DONE;
                            r_res_slot <= r_sel;
                            r_res_len  <= sel_ok ? fill_rd : '0;
                            r_state    <= S_FINISH;
                        end
                    endcase
                end
                S_APPEND: begin
                    if (r_cnt != '0) begin
                        // a write to position 0 also renames the group
                        if (r_waddr == grp_base(r_grp)) begin
                            r_id[r_grp] <= wr_byte;
                        end
                        r_waddr <= r_waddr + ADDR_W'(1);
                        r_bidx  <= r_bidx + 3'd1;
                        r_cnt   <= r_cnt - CNT_W'(1);
                    end else begin
                        r_fill[r_grp] <= r_new_fill;
                        r_state       <= S_FINISH;
                    end
                end
                S_CLEAR: begin
                    r_waddr <= r_waddr + ADDR_W'(1);
                    r_cnt   <= r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (!r_m_valid || i_m_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_user  <= M_TUSER_W'(r_res_st);
                        r_m_data  <= {6'd0, out_rb, 7'(r_res_len), r_res_slot};
                        r_state   <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;

    // Append writes stay inside the chosen group
    a_append_in_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_APPEND) && (r_cnt != '0))
        |-> (32'(r_waddr - grp_base(r_grp)) < BYTES_PER_GROUP))
        else $error("append write outside its group");

    // At most one frame's worth of bytes per append
    a_append_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPEND) |-> (r_cnt <= CNT_W'(FRAME_BYTES)))
        else $error("append byte count too large");

    // A new result only comes out of the finish state
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_state == S_FINISH))
        else $error("result raised outside finish");

    // Read data is fetched right before finish and held while waiting
    a_read_fetched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FINISH) && r_res_rb)
        |-> ($past(ram_re) || $past(r_state == S_FINISH)))
        else $error("read byte not fetched");

endmodule

/* dv/multi_frame_reassembly_buffer_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for multi_frame_reassembly_buffer: directed and random
// append/read/clear words with random stalls on both streams, checked against a
// local model of the group buffers. Depends on mfrb_pkg and the RTL.

import mfrb_pkg::*;

// Expected contents of one result word
typedef struct {
    t_status    status;
    logic [2:0] slot;
    logic [6:0] length;
    logic [7:0] rd_byte;
} t_reply;

// Mirror of the group buffers; predicts one reply per accepted input word
class reassembly_scoreboard;
    logic [7:0]  grp_bytes [GROUPS][BYTES_PER_GROUP];
    int unsigned grp_fill  [GROUPS];
    t_reply      awaited_replies [$];
    int unsigned mismatches;

    function new();
        foreach (grp_bytes[g, p]) grp_bytes[g][p] = 8'h00;
        foreach (grp_fill[g]) grp_fill[g] = 0;
        mismatches = 0;
    endfunction

    // First group whose id byte equals key, -1 if none
    function int find_group(logic [7:0] key);
        for (int g = 0; g < GROUPS; g++)
            if (grp_bytes[g][0] == key) return g;
        return -1;
    endfunction

    function void note_word(logic [1:0] op, logic [63:0] frame, logic [3:0] size_in,
                            logic [2:0] sel, logic [5:0] off);
        t_reply      rep;
        int          g;
        int unsigned size, len, k;
        rep.status  = ST_DONE;
        rep.slot    = sel;
        rep.length  = '0;
        rep.rd_byte = '0;
        case (op)
            OP_APPEND: begin
                size = (size_in == 0) ? 1 : (size_in > FRAME_BYTES) ? FRAME_BYTES : size_in;
                g = find_group(frame[7:0]);
                if (g < 0) begin
                    // unknown id: claim the first free group
                    g = find_group(8'h00);
                    if (g < 0) begin
                        rep.status = ST_NO_FREE;
                        rep.slot   = '0;
                    end else begin
                        for (k = 0; k < size; k++) grp_bytes[g][k] = frame[8*k +: 8];
                        grp_fill[g] = FRAME_BYTES;
                        rep.status  = ST_NEW;
                        rep.slot    = 3'(g);
                        rep.length  = 7'(grp_fill[g]);
                    end
                end else begin
                    // known group (or id zero hitting a free one)
                    len = grp_fill[g];
                    rep.slot = 3'(g);
                    if (len + size > BYTES_PER_GROUP) begin
                        rep.status = ST_OVERFLOW;
                        rep.length = 7'(len);
                    end else begin
                        for (k = 1; k < size; k++) grp_bytes[g][len + k - 1] = frame[8*k +: 8];
                        grp_fill[g] = len + size - 1;
                        rep.status  = ST_APPENDED;
                        rep.length  = 7'(grp_fill[g]);
                    end
                end
            end
            OP_READ: begin
                if (sel < GROUPS) begin
                    rep.length = 7'(grp_fill[sel]);
                    if (off + 1 < BYTES_PER_GROUP) rep.rd_byte = grp_bytes[sel][off + 1];
                end
            end
            OP_CLEAR: begin
                if (sel < GROUPS) begin
                    for (k = 0; k < BYTES_PER_GROUP; k++) grp_bytes[sel][k] = 8'h00;
                    grp_fill[sel] = 0;
                end
            end
            default: begin
                if (sel < GROUPS) rep.length = 7'(grp_fill[sel]);
            end
        endcase
        awaited_replies.push_back(rep);
    endfunction

    function void check_word(logic [2:0] st, logic [23:0] data);
        t_reply rep;
        if (awaited_replies.size() == 0) begin
            $display("%0t: unexpected result word status=%0d tdata=%h", $time, st, data);
            mismatches++;
            return;
        end
        rep = awaited_replies.pop_front();
        if (st != rep.status) begin
            $display("%0t: status expected %0d actual %0d", $time, rep.status, st);
            mismatches++;
        end
        if (data[2:0] != rep.slot) begin
            $display("%0t: group_slot expected %0d actual %0d", $time, rep.slot, data[2:0]);
            mismatches++;
        end
        if (data[9:3] != rep.length) begin
            $display("%0t: group_length expected %0d actual %0d", $time, rep.length,
                     data[9:3]);
            mismatches++;
        end
        if (data[17:10] != rep.rd_byte) begin
            $display("%0t: read_byte expected %h actual %h", $time, rep.rd_byte, data[17:10]);
            mismatches++;
        end
        if (data[23:18] != '0) begin
            $display("%0t: tdata pad expected 0 actual %h", $time, data[23:18]);
            mismatches++;
        end
    endfunction
endclass

module multi_frame_reassembly_buffer_test;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int         CYCLE_LIMIT = 600000;
    localparam int         RANDOM_WORDS = 900;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata;
    logic [S_TUSER_W-1:0] i_s_tuser;
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic [M_TUSER_W-1:0] o_m_tuser;

    reassembly_scoreboard board = new();
    int unsigned          cycle_count = 0;
    bit                   src_calm = 0;
    bit                   sink_calm = 0;

    multi_frame_reassembly_buffer uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) board.check_word(o_m_tuser, o_m_tdata);
    end

    // Idle length: mostly short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Result sink: random stalls, with calm stretches
    initial begin
        int stall_left;
        int phase_cycles;
        stall_left   = 0;
        phase_cycles = 0;
        i_m_tready   = 1'b0;
        forever begin
            @(negedge i_clk);
            phase_cycles++;
            if (phase_cycles == 1500) begin
                phase_cycles = 0;
                sink_calm = ($urandom_range(0, 2) == 0);
            end
            if (stall_left > 0) begin
                i_m_tready = 1'b0;
                stall_left--;
            end else begin
                i_m_tready = 1'b1;
                if (!sink_calm && $urandom_range(0, 99) < 30) stall_left = pick_gap();
            end
        end
    end

    // Drive one word; called right after a falling edge, returns after one
    task automatic send_word(input logic [1:0] op, input logic [63:0] frame,
                             input logic [3:0] size, input logic [2:0] sel,
                             input logic [5:0] off);
        int gap;
        gap = src_calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tuser  = op;
        i_s_tdata  = {3'b000, off, sel, size, frame};
        do @(posedge i_clk); while (!o_s_tready);
        board.note_word(op, frame, size, sel, off);
        @(negedge i_clk);
    endtask

    task automatic drain_replies();
        i_s_tvalid = 1'b0;
        while (board.awaited_replies.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [63:0] rand_frame(logic [7:0] id);
        logic [63:0] f;
        f = {$urandom(), $urandom()};
        f[7:0] = id;
        return f;
    endfunction

    // Stimulus
    initial begin
        logic [7:0]  id_pool [8];
        logic [7:0]  id;
        logic [3:0]  size;
        int          r;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty read, fill group 0 to overflow, edge offsets
        send_word(OP_READ, 64'h0, 4'd1, 3'd0, 6'd0);
        send_word(OP_APPEND, 64'hFFEE_DDCC_BBAA_9911, 4'd8, 3'd0, 6'd0);
        repeat (8) send_word(OP_APPEND, rand_frame(8'h11), 4'd8, 3'd0, 6'd0);
        send_word(OP_APPEND, rand_frame(8'h11), 4'd7, 3'd0, 6'd0);
        send_word(OP_READ, 64'h0, 4'd1, 3'd0, 6'd62);
        send_word(OP_READ, 64'h0, 4'd1, 3'd0, 6'd63);
        send_word(OP_READ, 64'h0, 4'd1, 3'd0, 6'd0);
        // size 1, size zero clamped, size above eight clamped
        send_word(OP_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, 4'd1, 3'd7, 6'd63);
        send_word(OP_APPEND, 64'h0000_0000_0000_00FF, 4'd0, 3'd0, 6'd0);
        send_word(OP_APPEND, 64'h0000_0000_0000_00FF, 4'd15, 3'd0, 6'd0);
        // id zero lands on the first free group
        send_word(OP_APPEND, 64'h1234_5678_9A00_3300, 4'd3, 3'd0, 6'd0);
        send_word(OP_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 3'd2, 6'd63);
        // take the remaining groups, then one id too many
        for (int i = 0; i < 5; i++)
            send_word(OP_APPEND, rand_frame(8'h44 + 8'(i * 8'h11)), 4'd8, 3'd0, 6'd0);
        send_word(OP_APPEND, rand_frame(8'h99), 4'd8, 3'd0, 6'd0);
        send_word(OP_CLEAR, 64'h0, 4'd1, 3'd3, 6'd0);
        send_word(OP_READ, 64'h0, 4'd1, 3'd3, 6'd0);
        drain_replies();

        // Random: a small working set of ids so groups fill, overflow and recycle
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 120 == 0) begin
                foreach (id_pool[i]) id_pool[i] = 8'($urandom_range(1, 255));
                src_calm = ($urandom_range(0, 3) == 0);
            end
            if (n == RANDOM_WORDS / 2) drain_replies();
            r = $urandom_range(0, 99);
            if (r < 58) begin
                if ($urandom_range(0, 49) == 0) id = 8'h00;
                else if ($urandom_range(0, 19) == 0) id = 8'($urandom_range(0, 255));
                else id = id_pool[$urandom_range(0, 5)];
                r = $urandom_range(0, 99);
                if (r < 70) size = 4'd8;
                else if (r < 92) size = 4'($urandom_range(1, 7));
                else size = 4'($urandom_range(0, 15));
                send_word(OP_APPEND, rand_frame(id), size, 3'($urandom_range(0, 7)),
                          6'($urandom_range(0, 63)));
            end else if (r < 80) begin
                send_word(OP_READ, rand_frame(8'($urandom_range(0, 255))),
                          4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
                          ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, 15))
                                                     : 6'($urandom_range(0, 63)));
            end else if (r < 95) begin
                send_word(OP_CLEAR, rand_frame(8'($urandom_range(0, 255))),
                          4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
                          6'($urandom_range(0, 63)));
            end else begin
                send_word(OP_UNUSED, rand_frame(8'($urandom_range(0, 255))),
                          4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
                          6'($urandom_range(0, 63)));
            end
        end

        // Wait out the last replies, then a margin for stray words
        drain_replies();
        repeat (200) @(posedge i_clk);
        if (board.mismatches == 0 && board.awaited_replies.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/mfrb_pkg.sv
rtl/mfrb_ram.sv
rtl/multi_frame_reassembly_buffer.sv
dv/multi_frame_reassembly_buffer_test.sv
